// ===== sv/msp_pkg.sv =====
package msp_pkg;

    // Result kinds on the output channel
    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_SYSEX = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    // MIDI byte codes
    localparam logic [7:0] STATUS_MIN     = 8'h80;
    localparam logic [7:0] SYSEX_START    = 8'hf0;
    localparam logic [7:0] SYSEX_END      = 8'hf7;
    localparam logic [7:0] REALTIME_MIN   = 8'hf8;
    localparam logic [7:0] SYS_MIN        = 8'hf0;
    localparam logic [7:0] TIME_CODE      = 8'hf1;
    localparam logic [7:0] SONG_POSITION  = 8'hf2;
    localparam logic [7:0] SONG_SELECT    = 8'hf3;
    localparam logic [3:0] HI_PROG_CHANGE = 4'hc;
    localparam logic [3:0] HI_CHAN_PRESS  = 4'hd;
    localparam logic [3:0] HI_PITCH_BEND  = 4'he;
    localparam logic [3:0] HI_SYSTEM      = 4'hf;

    // Output queue depth
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] message;
        logic [7:0]  sysex_byte;
        logic        chunk_last;
        logic        last;
    } result_t;

    // Up to two results from one decoded byte
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } dec_out_t;

    // Number of data bytes a status byte takes: 0, 1 or 2
    function automatic logic [1:0] need_data(input logic [7:0] s);
        logic [1:0] n;
        n = 2'd0;
        case (s[7:4])
            HI_PROG_CHANGE, HI_CHAN_PRESS: n = 2'd1;
            HI_SYSTEM:
            begin
                if (s == TIME_CODE || s == SONG_SELECT)
                    n = 2'd1;
                else if (s == SONG_POSITION)
                    n = 2'd2;
                else
                    n = 2'd0;
            end
            default:
            begin
                if (s[7])
                    n = 2'd2;
                else
                    n = 2'd0;
            end
        endcase
        return n;
    endfunction

endpackage

// ===== sv/msp_decode.sv =====
module msp_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        data_byte,
    input  logic              packet_end,
    output msp_pkg::dec_out_t dec
);

    logic [7:0] running_status_reg, running_status_next;
    logic       in_sysex_reg, in_sysex_next;
    logic [7:0] pending_status_reg, pending_status_next;
    logic       have_first_reg, have_first_next;
    logic [6:0] first_data_reg, first_data_next;

    // Decode one byte against the parser state
    always_comb
    begin
        logic             abort;
        logic             has_main;
        logic             handled;
        logic [1:0]       want;
        msp_pkg::result_t main_res;
        msp_pkg::result_t abort_res;

        running_status_next = running_status_reg;
        in_sysex_next       = in_sysex_reg;
        pending_status_next = pending_status_reg;
        have_first_next     = have_first_reg;
        first_data_next     = first_data_reg;
        abort               = 1'b0;
        has_main            = 1'b0;
        handled             = 1'b0;
        want                = 2'd0;
        main_res            = '0;
        abort_res           = '0;
        abort_res.kind      = msp_pkg::KIND_ABORT;

        if (data_byte >= msp_pkg::REALTIME_MIN)
        begin
            // pass real-time straight through
            has_main         = 1'b1;
            main_res.kind    = msp_pkg::KIND_SHORT;
            main_res.message = {16'd0, data_byte};
        end
        else
        begin
            if (in_sysex_reg)
            begin
                if (!data_byte[7])
                begin
                    has_main            = 1'b1;
                    handled             = 1'b1;
                    main_res.kind       = msp_pkg::KIND_SYSEX;
                    main_res.sysex_byte = data_byte;
                    main_res.chunk_last = packet_end;
                end
                else if (data_byte == msp_pkg::SYSEX_END)
                begin
                    has_main            = 1'b1;
                    handled             = 1'b1;
                    in_sysex_next       = 1'b0;
                    main_res.kind       = msp_pkg::KIND_SYSEX;
                    main_res.sysex_byte = data_byte;
                    main_res.chunk_last = 1'b1;
                end
                else
                begin
                    // another status byte aborts the sysex
                    abort         = 1'b1;
                    in_sysex_next = 1'b0;
                end
            end

            if (!handled)
            begin
                if (data_byte == msp_pkg::SYSEX_START)
                begin
                    in_sysex_next       = 1'b1;
                    running_status_next = '0;
                    pending_status_next = '0;
                    have_first_next     = 1'b0;
                    has_main            = 1'b1;
                    main_res.kind       = msp_pkg::KIND_SYSEX;
                    main_res.sysex_byte = data_byte;
                    main_res.chunk_last = packet_end;
                end
                else if (data_byte[7])
                begin
                    running_status_next = (data_byte < msp_pkg::SYS_MIN) ? data_byte : '0;
                    have_first_next     = 1'b0;
                    if (msp_pkg::need_data(data_byte) == 2'd0)
                    begin
                        pending_status_next = '0;
                        has_main            = 1'b1;
                        main_res.kind       = msp_pkg::KIND_SHORT;
                        main_res.message    = {16'd0, data_byte};
                    end
                    else
                    begin
                        pending_status_next = data_byte;
                    end
                end
                else
                begin
                    // resume running status when nothing is being gathered
                    if (pending_status_reg == '0 && running_status_reg != '0)
                    begin
                        pending_status_next = running_status_reg;
                        have_first_next     = 1'b0;
                    end
                    if (pending_status_next != '0)
                    begin
                        want = msp_pkg::need_data(pending_status_next);
                        if (want == 2'd2 && !have_first_next)
                        begin
                            first_data_next = data_byte[6:0];
                            have_first_next = 1'b1;
                        end
                        else
                        begin
                            has_main      = 1'b1;
                            main_res.kind = msp_pkg::KIND_SHORT;
                            if (want == 2'd2)
                                main_res.message = {data_byte, 1'b0, first_data_reg,
                                                    pending_status_next};
                            else
                                main_res.message = {8'd0, data_byte, pending_status_next};
                            pending_status_next = '0;
                            have_first_next     = 1'b0;
                        end
                    end
                    // stray data without status is dropped
                end
            end
        end

        // drop a partial message at packet end
        if (packet_end)
        begin
            pending_status_next = '0;
            have_first_next     = 1'b0;
        end

        // order the results, abort marker first
        dec = '0;
        if (abort)
        begin
            dec.res0 = abort_res;
            if (has_main)
            begin
                dec.res1      = main_res;
                dec.res1.last = 1'b1;
                dec.count     = 2'd2;
            end
            else
            begin
                dec.res0.last = 1'b1;
                dec.count     = 2'd1;
            end
        end
        else if (has_main)
        begin
            dec.res0      = main_res;
            dec.res0.last = 1'b1;
            dec.count     = 2'd1;
        end
    end

    // Advance parser state on each decoded byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_status_reg <= '0;
            in_sysex_reg       <= 1'b0;
            pending_status_reg <= '0;
            have_first_reg     <= 1'b0;
            first_data_reg     <= '0;
        end
        else if (fire)
        begin
            running_status_reg <= running_status_next;
            in_sysex_reg       <= in_sysex_next;
            pending_status_reg <= pending_status_next;
            have_first_reg     <= have_first_next;
            first_data_reg     <= first_data_next;
        end
    end

    // Running status only ever holds a channel status byte
    assert property (@(posedge clk) disable iff (!rst_n)
        running_status_reg == '0 ||
        (running_status_reg[7] && running_status_reg < msp_pkg::SYS_MIN))
    else $error("running status outside channel range");

    // Two results only come from an aborted sysex
    assert property (@(posedge clk) disable iff (!rst_n)
        dec.count == 2'd2 |-> in_sysex_reg && dec.res0.kind == msp_pkg::KIND_ABORT)
    else $error("double result without sysex abort");

    // A first data byte is only held while a message is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        have_first_reg |-> pending_status_reg != '0)
    else $error("first data held with no pending status");

endmodule

// ===== sv/msp_out_queue.sv =====
module msp_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  msp_pkg::dec_out_t dec,
    output logic              room,
    output logic              head_valid,
    input  logic              pop,
    output msp_pkg::result_t  head
);

    localparam int PtrW = $clog2(msp_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(msp_pkg::QUEUE_DEPTH + 1);

    msp_pkg::result_t entry_reg [msp_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic [CntW-1:0]  push_n;
    logic [CntW-1:0]  pop_n;
    logic             do_pop;

    // Room for the largest burst one byte can give
    assign room       = count_reg <= CntW'(msp_pkg::QUEUE_DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    assign push_n = push ? CntW'(dec.count) : '0;
    assign pop_n  = do_pop ? CntW'(1) : '0;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push_n);
        rd_ptr_next = rd_ptr_reg + PtrW'(pop_n);
        count_next  = count_reg + push_n - pop_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write up to two results per beat
    always_ff @(posedge clk)
    begin
        if (push && dec.count != 2'd0)
            entry_reg[wr_ptr_reg] <= dec.res0;
        if (push && dec.count == 2'd2)
            entry_reg[wr_ptr_reg + PtrW'(1)] <= dec.res1;
    end

    // Fill count never exceeds the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(msp_pkg::QUEUE_DEPTH))
    else $error("output queue overflow");

    // Pushes only when the burst fits
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
    else $error("push without room");

    // Count tracks pointer difference
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != CntW'(msp_pkg::QUEUE_DEPTH) |->
        PtrW'(wr_ptr_reg - rd_ptr_reg) == PtrW'(count_reg))
    else $error("queue pointers out of step with count");

endmodule

// ===== sv/midi_stream_splitter.sv =====
// MIDI byte stream splitter. Each raw byte beat, flagged with packet_end, goes
// into an input register and is decoded combinationally against running-status
// and sysex state; its results (none, one, or two when a status byte aborts a
// sysex) drop into a four-entry output queue. The block takes one byte per cycle
// unless stalled, and each result passes through the input register and then an
// output queue entry before it appears at the output. The input is stalled only
// while the output queue holds more than two results, so a byte per cycle is
// sustained as long as the output side takes one result per cycle and aborted sysex markers are sparse.
module midi_stream_splitter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        packet_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [23:0] message,
    output logic [7:0]  sysex_byte,
    output logic        chunk_last,
    output logic        last
);

    logic              byte_valid_reg;
    logic [7:0]        byte_reg;
    logic              packet_end_reg;
    logic              room;
    logic              fire;
    msp_pkg::dec_out_t dec;
    msp_pkg::result_t  head;

    // Decode the held beat when the queue can take its results
    assign fire     = byte_valid_reg && room;
    assign in_stall = byte_valid_reg && !room;

    // Hold the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (!in_stall)
            byte_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg       <= data_byte;
            packet_end_reg <= packet_end;
        end
    end

    msp_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .data_byte  (byte_reg),
        .packet_end (packet_end_reg),
        .dec        (dec)
    );

    msp_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire),
        .dec        (dec),
        .room       (room),
        .head_valid (out_valid),
        .pop        (!out_stall),
        .head       (head)
    );

    // Drive the result fields from the queue head
    assign kind       = head.kind;
    assign message    = head.message;
    assign sysex_byte = head.sysex_byte;
    assign chunk_last = head.chunk_last;
    assign last       = head.last;

endmodule
